@@ rtl/script_token_scanner_assert.svh @@
// ----------------------------------------------------------------------------
// script token scanner assertion macros
// concurrent checks on one clock with a synchronous reset that disables them
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_SCANNER_ASSERT_SVH
`define SCRIPT_TOKEN_SCANNER_ASSERT_SVH
`ifndef SYNTHESIS
// expression must hold at every edge out of reset
`define STC_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("check failed: expression does not hold");
// same-cycle implication
`define STC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");
// next-cycle implication
`define STC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");
`else
`define STC_ASSERT(lbl, clk, rst, expr)
`define STC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define STC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg
// shared constants, codes, tables and types of the script token scanner
// ----------------------------------------------------------------------------
package stc_pkg;

   // internal counter widths
   localparam int OFFSET_BITS = 32;
   localparam int LENGTH_BITS = 16;
   localparam int LINE_BITS   = 16;

   // record field widths
   localparam int KIND_W  = 5;
   localparam int ERR_W   = 2;
   localparam int START_W = 32;
   localparam int LEN_W   = 16;
   localparam int LINE_W  = 16;

   localparam int RSP_FIELDS_W = ERR_W + START_W + LEN_W + LINE_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // keyword prefix store
   localparam int KW_CHARS  = 6;
   localparam int KW_W      = 8 * KW_CHARS;
   localparam int KW_NUM    = 9;
   localparam int PUNCT_NUM = 11;

   // output queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // scan modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_IDENT   = 3'd1;
   localparam logic [2:0] MODE_NUM     = 3'd2;
   localparam logic [2:0] MODE_STR     = 3'd3;
   localparam logic [2:0] MODE_EQ      = 3'd4;
   localparam logic [2:0] MODE_BANG    = 3'd5;
   localparam logic [2:0] MODE_LESS    = 3'd6;
   localparam logic [2:0] MODE_GREATER = 3'd7;

   // token kinds
   localparam logic [KIND_W-1:0] K_EOF           = 5'd0;
   localparam logic [KIND_W-1:0] K_ERROR         = 5'd1;
   localparam logic [KIND_W-1:0] K_IDENT         = 5'd2;
   localparam logic [KIND_W-1:0] K_NUMBER        = 5'd3;
   localparam logic [KIND_W-1:0] K_STRING        = 5'd4;
   localparam logic [KIND_W-1:0] K_PUNCT0        = 5'd5;
   localparam logic [KIND_W-1:0] K_EQUAL         = 5'd16;
   localparam logic [KIND_W-1:0] K_EQUAL_EQUAL   = 5'd17;
   localparam logic [KIND_W-1:0] K_BANG_EQUAL    = 5'd18;
   localparam logic [KIND_W-1:0] K_LESS          = 5'd19;
   localparam logic [KIND_W-1:0] K_LESS_EQUAL    = 5'd20;
   localparam logic [KIND_W-1:0] K_GREATER       = 5'd21;
   localparam logic [KIND_W-1:0] K_GREATER_EQUAL = 5'd22;
   localparam logic [KIND_W-1:0] K_KEYWORD0      = 5'd23;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNEXPECTED   = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNTERMINATED = 2'd2;
   localparam logic [ERR_W-1:0] ERR_LONE_BANG    = 2'd3;

   // characters
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_LESS       = 8'h3C;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_GREATER    = 8'h3E;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   // ( ) { } [ ] . : , + -
   localparam logic [7:0] PUNCT_CHARS [PUNCT_NUM] = '{
      8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2E, 8'h3A, 8'h2C, 8'h2B, 8'h2D
   };

   // and else func if not or print return while, first char in the low byte
   localparam logic [KW_W-1:0] KW_TEXT [KW_NUM] = '{
      48'h000000646E61, 48'h000065736C65, 48'h0000636E7566,
      48'h000000006669, 48'h000000746F6E, 48'h00000000726F,
      48'h00746E697270, 48'h6E7275746572, 48'h00656C696877
   };
   localparam logic [2:0] KW_LEN [KW_NUM] = '{
      3'd3, 3'd4, 3'd4, 3'd2, 3'd3, 3'd2, 3'd5, 3'd6, 3'd5
   };

   typedef struct packed {
      logic       action;
      logic [7:0] source_byte;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  token_kind;
      logic [ERR_W-1:0]   error_code;
      logic [START_W-1:0] start_offset;
      logic [LEN_W-1:0]   token_length;
      logic [LINE_W-1:0]  line_number;
      logic               last;
   } rec_type;

   // records produced by one item, in order
   typedef struct packed {
      logic [1:0] n;
      rec_type    rec0;
      rec_type    rec1;
   } push_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDERSCORE;
   endfunction

   function automatic logic is_decimal(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

@@ rtl/stc_scan_core.sv @@
// ----------------------------------------------------------------------------
// stc_scan_core
// scanner state and per-byte token rules, up to two records per item
// ----------------------------------------------------------------------------
`include "script_token_scanner_assert.svh"

module stc_scan_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  stc_pkg::item_type  item,
   output stc_pkg::push_type  push
);

   logic [2:0]                        mode_ff,  mode_in;
   logic [stc_pkg::OFFSET_BITS-1:0]   pos_ff,   pos_in;
   logic [stc_pkg::OFFSET_BITS-1:0]   start_ff, start_in;
   logic [stc_pkg::LENGTH_BITS-1:0]   count_ff, count_in;
   logic [stc_pkg::LINE_BITS-1:0]     line_ff,  line_in;
   logic [stc_pkg::KW_W-1:0]          kw_ff,    kw_in;

   logic                              is_end;
   logic [stc_pkg::LENGTH_BITS-1:0]   cnt_inc;
   logic [stc_pkg::LINE_BITS-1:0]     line_inc;
   logic [stc_pkg::KIND_W-1:0]        ident_k;
   logic                              punct_hit;
   logic [stc_pkg::KIND_W-1:0]        punct_k;
   logic [stc_pkg::KIND_W-1:0]        op_eq_k;
   stc_pkg::rec_type                  flush_rec;

   function automatic stc_pkg::rec_type mk_rec(
      input logic [stc_pkg::KIND_W-1:0]      kind,
      input logic [stc_pkg::ERR_W-1:0]       err,
      input logic [stc_pkg::OFFSET_BITS-1:0] start,
      input logic [stc_pkg::LENGTH_BITS-1:0] len,
      input logic [stc_pkg::LINE_BITS-1:0]   line
   );
      stc_pkg::rec_type r;
      r.token_kind   = kind;
      r.error_code   = err;
      r.start_offset = stc_pkg::START_W'(start);
      r.token_length = stc_pkg::LEN_W'(len);
      r.line_number  = stc_pkg::LINE_W'(line);
      r.last         = 1'b0;
      return r;
   endfunction

   assign is_end   = item.action || item.source_byte == stc_pkg::CH_NUL;
   assign cnt_inc  = (&count_ff) ? count_ff : count_ff + 1'b1;
   assign line_inc = (&line_ff) ? line_ff : line_ff + 1'b1;

   // keyword match on length and stored prefix
   always_comb begin
      ident_k = stc_pkg::K_IDENT;
      for (int k = 0; k < stc_pkg::KW_NUM; k++) begin
         if (count_ff == stc_pkg::LENGTH_BITS'(stc_pkg::KW_LEN[k]) &&
             kw_ff == stc_pkg::KW_TEXT[k]) begin
            ident_k = stc_pkg::K_KEYWORD0 + stc_pkg::KIND_W'(k);
         end
      end
   end

   always_comb begin
      punct_hit = 1'b0;
      punct_k   = stc_pkg::K_ERROR;
      for (int i = 0; i < stc_pkg::PUNCT_NUM; i++) begin
         if (item.source_byte == stc_pkg::PUNCT_CHARS[i]) begin
            punct_hit = 1'b1;
            punct_k   = stc_pkg::K_PUNCT0 + stc_pkg::KIND_W'(i);
         end
      end
   end

   always_comb begin
      case (mode_ff)
         stc_pkg::MODE_EQ:   op_eq_k = stc_pkg::K_EQUAL_EQUAL;
         stc_pkg::MODE_BANG: op_eq_k = stc_pkg::K_BANG_EQUAL;
         stc_pkg::MODE_LESS: op_eq_k = stc_pkg::K_LESS_EQUAL;
         default:            op_eq_k = stc_pkg::K_GREATER_EQUAL;
      endcase
   end

   // record for the pending token when it is closed by some other byte or by the end of source
   always_comb begin
      case (mode_ff)
         stc_pkg::MODE_IDENT:
            flush_rec = mk_rec(ident_k, stc_pkg::ERR_NONE, start_ff, count_ff, line_ff);
         stc_pkg::MODE_NUM:
            flush_rec = mk_rec(stc_pkg::K_NUMBER, stc_pkg::ERR_NONE, start_ff, count_ff, line_ff);
         stc_pkg::MODE_STR:
            flush_rec = mk_rec(stc_pkg::K_ERROR, stc_pkg::ERR_UNTERMINATED, start_ff, count_ff,
                               line_ff);
         stc_pkg::MODE_EQ:
            flush_rec = mk_rec(stc_pkg::K_EQUAL, stc_pkg::ERR_NONE, start_ff,
                               stc_pkg::LENGTH_BITS'(1), line_ff);
         stc_pkg::MODE_BANG:
            flush_rec = mk_rec(stc_pkg::K_ERROR, stc_pkg::ERR_LONE_BANG, start_ff,
                               stc_pkg::LENGTH_BITS'(1), line_ff);
         stc_pkg::MODE_LESS:
            flush_rec = mk_rec(stc_pkg::K_LESS, stc_pkg::ERR_NONE, start_ff,
                               stc_pkg::LENGTH_BITS'(1), line_ff);
         stc_pkg::MODE_GREATER:
            flush_rec = mk_rec(stc_pkg::K_GREATER, stc_pkg::ERR_NONE, start_ff,
                               stc_pkg::LENGTH_BITS'(1), line_ff);
         default:
            flush_rec = mk_rec(stc_pkg::K_EOF, stc_pkg::ERR_NONE, start_ff, count_ff, line_ff);
      endcase
   end

   always_comb begin
      logic             taken;
      logic             a_v;
      logic             b_v;
      stc_pkg::rec_type a_rec;
      stc_pkg::rec_type b_rec;
      logic [7:0]       c;

      c        = item.source_byte;
      taken    = 1'b0;
      a_v      = 1'b0;
      b_v      = 1'b0;
      a_rec    = flush_rec;
      b_rec    = flush_rec;
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      count_in = count_ff;
      line_in  = line_ff;
      kw_in    = kw_ff;

      if (item_valid) begin
         pos_in = pos_ff + 1'b1;
         if (is_end) begin
            a_v      = mode_ff != stc_pkg::MODE_IDLE;
            b_v      = 1'b1;
            b_rec    = mk_rec(stc_pkg::K_EOF, stc_pkg::ERR_NONE, pos_ff, '0, line_ff);
            mode_in  = stc_pkg::MODE_IDLE;
            pos_in   = '0;
            start_in = '0;
            count_in = '0;
            line_in  = stc_pkg::LINE_BITS'(1);
            kw_in    = '0;
         end else begin
            case (mode_ff)
               stc_pkg::MODE_IDENT: begin
                  if (stc_pkg::is_letter(c) || stc_pkg::is_decimal(c)) begin
                     taken = 1'b1;
                     for (int i = 0; i < stc_pkg::KW_CHARS; i++) begin
                        if (count_ff == stc_pkg::LENGTH_BITS'(i)) kw_in[8*i +: 8] = c;
                     end
                     count_in = cnt_inc;
                  end
               end
               stc_pkg::MODE_NUM: begin
                  if (stc_pkg::is_decimal(c)) begin
                     taken    = 1'b1;
                     count_in = cnt_inc;
                  end
               end
               stc_pkg::MODE_STR: begin
                  taken    = 1'b1;
                  count_in = cnt_inc;
                  if (c == stc_pkg::CH_QUOTE) begin
                     a_v     = 1'b1;
                     a_rec   = mk_rec(stc_pkg::K_STRING, stc_pkg::ERR_NONE, start_ff, cnt_inc,
                                      line_ff);
                     mode_in = stc_pkg::MODE_IDLE;
                  end else if (c == stc_pkg::CH_NEWLINE) begin
                     line_in = line_inc;
                  end
               end
               stc_pkg::MODE_EQ, stc_pkg::MODE_BANG, stc_pkg::MODE_LESS,
               stc_pkg::MODE_GREATER: begin
                  if (c == stc_pkg::CH_EQUAL) begin
                     taken   = 1'b1;
                     a_v     = 1'b1;
                     a_rec   = mk_rec(op_eq_k, stc_pkg::ERR_NONE, start_ff,
                                      stc_pkg::LENGTH_BITS'(2), line_ff);
                     mode_in = stc_pkg::MODE_IDLE;
                  end
               end
               default: begin
               end
            endcase

            if (!taken) begin
               // close any pending token, then scan the byte from idle
               a_v     = mode_ff != stc_pkg::MODE_IDLE;
               a_rec   = flush_rec;
               mode_in = stc_pkg::MODE_IDLE;
               if (c == stc_pkg::CH_SPACE || c == stc_pkg::CH_TAB || c == stc_pkg::CH_CR) begin
                  mode_in = stc_pkg::MODE_IDLE;
               end else if (c == stc_pkg::CH_NEWLINE) begin
                  line_in = line_inc;
               end else if (stc_pkg::is_letter(c)) begin
                  mode_in  = stc_pkg::MODE_IDENT;
                  start_in = pos_ff;
                  count_in = stc_pkg::LENGTH_BITS'(1);
                  kw_in    = stc_pkg::KW_W'(c);
               end else if (stc_pkg::is_decimal(c)) begin
                  mode_in  = stc_pkg::MODE_NUM;
                  start_in = pos_ff;
                  count_in = stc_pkg::LENGTH_BITS'(1);
               end else if (c == stc_pkg::CH_QUOTE) begin
                  mode_in  = stc_pkg::MODE_STR;
                  start_in = pos_ff;
                  count_in = stc_pkg::LENGTH_BITS'(1);
               end else if (c == stc_pkg::CH_EQUAL) begin
                  mode_in  = stc_pkg::MODE_EQ;
                  start_in = pos_ff;
                  count_in = stc_pkg::LENGTH_BITS'(1);
               end else if (c == stc_pkg::CH_BANG) begin
                  mode_in  = stc_pkg::MODE_BANG;
                  start_in = pos_ff;
                  count_in = stc_pkg::LENGTH_BITS'(1);
               end else if (c == stc_pkg::CH_LESS) begin
                  mode_in  = stc_pkg::MODE_LESS;
                  start_in = pos_ff;
                  count_in = stc_pkg::LENGTH_BITS'(1);
               end else if (c == stc_pkg::CH_GREATER) begin
                  mode_in  = stc_pkg::MODE_GREATER;
                  start_in = pos_ff;
                  count_in = stc_pkg::LENGTH_BITS'(1);
               end else if (punct_hit) begin
                  b_v   = 1'b1;
                  b_rec = mk_rec(punct_k, stc_pkg::ERR_NONE, pos_ff, stc_pkg::LENGTH_BITS'(1),
                                 line_ff);
               end else begin
                  b_v   = 1'b1;
                  b_rec = mk_rec(stc_pkg::K_ERROR, stc_pkg::ERR_UNEXPECTED, pos_ff,
                                 stc_pkg::LENGTH_BITS'(1), line_ff);
               end
            end
         end
      end

      // pack in order, last marks the final record of this item
      push.n         = {1'b0, a_v} + {1'b0, b_v};
      push.rec0      = a_v ? a_rec : b_rec;
      push.rec0.last = !(a_v && b_v);
      push.rec1      = b_rec;
      push.rec1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stc_pkg::MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         count_ff <= '0;
         line_ff  <= stc_pkg::LINE_BITS'(1);
         kw_ff    <= '0;
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         count_ff <= count_in;
         line_ff  <= line_in;
         kw_ff    <= kw_in;
      end
   end

   `STC_ASSERT_IMPL(a_two_needs_pending, clock, reset, push.n == 2'd2, mode_ff != stc_pkg::MODE_IDLE)
   `STC_ASSERT(a_at_most_two, clock, reset, push.n != 2'd3)
   `STC_ASSERT_NEXT(a_end_rearms, clock, reset, item_valid && is_end, mode_ff == stc_pkg::MODE_IDLE && pos_ff == '0 && line_ff == stc_pkg::LINE_BITS'(1))

endmodule

@@ rtl/stc_out_fifo.sv @@
// ----------------------------------------------------------------------------
// stc_out_fifo
// small record queue, takes up to two records a cycle and gives one
// ----------------------------------------------------------------------------
`include "script_token_scanner_assert.svh"

module stc_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  stc_pkg::push_type push,
   input  logic              pop,
   output logic              room,
   output logic              head_valid,
   output stc_pkg::rec_type  head
);

   stc_pkg::rec_type             mem_ff [stc_pkg::FIFO_DEPTH];
   stc_pkg::rec_type             mem_in [stc_pkg::FIFO_DEPTH];
   logic [stc_pkg::FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [stc_pkg::FIFO_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [stc_pkg::FIFO_CW-1:0]  count_ff,  count_in;
   logic [stc_pkg::FIFO_AW-1:0]  wr_ptr_nx;

   assign room       = count_ff <= stc_pkg::FIFO_CW'(stc_pkg::FIFO_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign wr_ptr_nx  = wr_ptr_ff + 1'b1;

   always_comb begin
      mem_in = mem_ff;
      if (push.n != 2'd0) mem_in[wr_ptr_ff] = push.rec0;
      if (push.n == 2'd2) mem_in[wr_ptr_nx] = push.rec1;
      wr_ptr_in = wr_ptr_ff + stc_pkg::FIFO_AW'(push.n);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + stc_pkg::FIFO_CW'(push.n) - stc_pkg::FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `STC_ASSERT(a_no_overflow, clock, reset, count_ff <= stc_pkg::FIFO_CW'(stc_pkg::FIFO_DEPTH))
   `STC_ASSERT_IMPL(a_push_has_room, clock, reset, push.n != 2'd0, room)
   `STC_ASSERT_NEXT(a_pop_drains, clock, reset, pop && push.n == 2'd0, count_ff == $past(count_ff) - 1'b1)

endmodule

@@ rtl/script_token_scanner.sv @@
// ----------------------------------------------------------------------------
// script_token_scanner
// streaming lexer: source bytes in, token records out
// ----------------------------------------------------------------------------
// a taken byte is held in the input register, then scanned into the output queue, whose head drives rsp
// throughput: one byte per cycle while the queue has room; a byte that closes a held token
//   and also emits its own record gives two words, drained one per cycle by the queue
//   while rsp is ready; the input stays open while the four-word output queue has room for two
// reset: synchronous, active high; clears scanner state (line count to one)
//   and empties the queue; no clearing pass
module script_token_scanner (
   input  logic                           clock,
   input  logic                           reset,

   // source byte channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] source_byte
   input  logic                           req_tuser,   // [0] action (1 = end of source)

   // token record channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [stc_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [1:0] error_code, [33:2] start_offset,
                                                       // [49:34] token_length,
                                                       // [65:50] line_number, rest zero
   output logic [stc_pkg::KIND_W-1:0]     rsp_tuser,   // [4:0] token_kind
   output logic                           rsp_tlast    // last record of the source word
);

   // input register
   logic              in_v_ff, in_v_in;
   stc_pkg::item_type in_ff,   in_in;

   logic              req_accept;
   logic              advance;
   logic              room;
   logic              head_valid;
   stc_pkg::rec_type  head;
   stc_pkg::push_type push;

   // a held word moves into the scanner whenever the queue can take two records
   assign req_tready = !in_v_ff || room;
   assign req_accept = req_tvalid && req_tready;
   assign advance    = in_v_ff && room;

   always_comb begin
      in_in   = req_accept ? stc_pkg::item_type'({req_tuser, req_tdata}) : in_ff;
      in_v_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_v_ff);
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
   end

   // token rules and scanner state
   stc_scan_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_ff),
      .push       (push)
   );

   // result buffer, absorbs the second record of a word
   stc_out_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tvalid && rsp_tready),
      .room       (room),
      .head_valid (head_valid),
      .head       (head)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tuser  = head.token_kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {{stc_pkg::RSP_PAD_W{1'b0}}, head.line_number, head.token_length,
                        head.start_offset, head.error_code};

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the script token scanner: source bytes go in on the
// req stream and each is run through a cycle-free token predictor; every
// record leaving rsp is matched field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;

   // ------------------------------------------------------------------------
   // token predictor and record store
   // ------------------------------------------------------------------------
   class token_scoreboard;
      typedef enum logic [2:0] {
         SCAN_IDLE, SCAN_IDENT, SCAN_NUM, SCAN_STR,
         SCAN_EQ, SCAN_BANG, SCAN_LESS, SCAN_GREATER
      } scan_state_e;

      string             keyword_words [9];
      string             punct_chars;
      scan_state_e       scan_state;
      logic [31:0]       byte_pos;
      logic [31:0]       tok_start;
      logic [15:0]       tok_len;
      logic [15:0]       line_no;
      logic [47:0]       ident_prefix;
      stc_pkg::rec_type  step_tokens [$];
      stc_pkg::rec_type  expected_tokens [$];
      int unsigned       mismatches;

      function new();
         keyword_words = '{"and", "else", "func", "if", "not", "or", "print", "return",
                           "while"};
         punct_chars = "(){}[].:,+-";
         mismatches = 0;
         rearm();
      endfunction

      function void rearm();
         scan_state = SCAN_IDLE;
         byte_pos = '0;
         tok_start = '0;
         tok_len = '0;
         line_no = 16'd1;
         ident_prefix = '0;
      endfunction

      function bit is_name_char(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                c == stc_pkg::CH_UNDERSCORE;
      endfunction

      function bit is_numeral(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function logic [15:0] bump(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function void add_token(logic [stc_pkg::KIND_W-1:0] kind,
                              logic [stc_pkg::ERR_W-1:0] err,
                              logic [31:0] start, logic [15:0] len);
         stc_pkg::rec_type r;
         r.token_kind   = kind;
         r.error_code   = err;
         r.start_offset = start;
         r.token_length = len;
         r.line_number  = line_no;
         r.last         = 1'b0;
         step_tokens.push_back(r);
      endfunction

      function logic [stc_pkg::KIND_W-1:0] ident_kind();
         logic [47:0] word_bits;
         for (int k = 0; k < 9; k++) begin
            word_bits = '0;
            for (int i = 0; i < keyword_words[k].len(); i++)
               word_bits[8*i +: 8] = keyword_words[k][i];
            if (tok_len == 16'(keyword_words[k].len()) && ident_prefix == word_bits)
               return stc_pkg::K_KEYWORD0 + 5'(k);
         end
         return stc_pkg::K_IDENT;
      endfunction

      // close whatever token is held
      function void flush_held();
         case (scan_state)
            SCAN_IDENT:   add_token(ident_kind(), stc_pkg::ERR_NONE, tok_start, tok_len);
            SCAN_NUM:     add_token(stc_pkg::K_NUMBER, stc_pkg::ERR_NONE, tok_start, tok_len);
            SCAN_STR:     add_token(stc_pkg::K_ERROR, stc_pkg::ERR_UNTERMINATED, tok_start,
                                    tok_len);
            SCAN_EQ:      add_token(stc_pkg::K_EQUAL, stc_pkg::ERR_NONE, tok_start, 16'd1);
            SCAN_BANG:    add_token(stc_pkg::K_ERROR, stc_pkg::ERR_LONE_BANG, tok_start, 16'd1);
            SCAN_LESS:    add_token(stc_pkg::K_LESS, stc_pkg::ERR_NONE, tok_start, 16'd1);
            SCAN_GREATER: add_token(stc_pkg::K_GREATER, stc_pkg::ERR_NONE, tok_start, 16'd1);
            default: ;
         endcase
         scan_state = SCAN_IDLE;
      endfunction

      function void open_token(scan_state_e st, logic [31:0] pos);
         scan_state = st;
         tok_start = pos;
         tok_len = 16'd1;
      endfunction

      // byte seen with nothing held
      function void scan_idle_byte(logic [7:0] c, logic [31:0] pos);
         if (c == stc_pkg::CH_SPACE || c == stc_pkg::CH_TAB || c == stc_pkg::CH_CR) return;
         if (c == stc_pkg::CH_NEWLINE) begin
            line_no = bump(line_no);
            return;
         end
         if (is_name_char(c)) begin
            open_token(SCAN_IDENT, pos);
            ident_prefix = {40'd0, c};
            return;
         end
         if (is_numeral(c)) begin open_token(SCAN_NUM, pos); return; end
         if (c == stc_pkg::CH_QUOTE) begin open_token(SCAN_STR, pos); return; end
         if (c == stc_pkg::CH_EQUAL) begin open_token(SCAN_EQ, pos); return; end
         if (c == stc_pkg::CH_BANG) begin open_token(SCAN_BANG, pos); return; end
         if (c == stc_pkg::CH_LESS) begin open_token(SCAN_LESS, pos); return; end
         if (c == stc_pkg::CH_GREATER) begin open_token(SCAN_GREATER, pos); return; end
         for (int i = 0; i < punct_chars.len(); i++) begin
            if (c == punct_chars[i]) begin
               add_token(stc_pkg::K_PUNCT0 + 5'(i), stc_pkg::ERR_NONE, pos, 16'd1);
               return;
            end
         end
         add_token(stc_pkg::K_ERROR, stc_pkg::ERR_UNEXPECTED, pos, 16'd1);
      endfunction

      // one accepted source word: predict its records
      function void note_input(logic action, logic [7:0] c);
         bit                         taken;
         logic [31:0]                pos;
         logic [stc_pkg::KIND_W-1:0] pair_kind;
         stc_pkg::rec_type           r;
         step_tokens.delete();
         taken = 1'b0;
         pos = byte_pos;
         if (action || c == stc_pkg::CH_NUL) begin
            flush_held();
            add_token(stc_pkg::K_EOF, stc_pkg::ERR_NONE, pos, 16'd0);
            rearm();
         end else begin
            case (scan_state)
               SCAN_IDENT: if (is_name_char(c) || is_numeral(c)) begin
                  if (tok_len < 16'd6) ident_prefix[8*tok_len +: 8] = c;
                  tok_len = bump(tok_len);
                  taken = 1'b1;
               end
               SCAN_NUM: if (is_numeral(c)) begin
                  tok_len = bump(tok_len);
                  taken = 1'b1;
               end
               SCAN_STR: begin
                  tok_len = bump(tok_len);
                  if (c == stc_pkg::CH_QUOTE) begin
                     add_token(stc_pkg::K_STRING, stc_pkg::ERR_NONE, tok_start, tok_len);
                     scan_state = SCAN_IDLE;
                  end else if (c == stc_pkg::CH_NEWLINE) begin
                     line_no = bump(line_no);
                  end
                  taken = 1'b1;
               end
               SCAN_EQ, SCAN_BANG, SCAN_LESS, SCAN_GREATER: if (c == stc_pkg::CH_EQUAL) begin
                  case (scan_state)
                     SCAN_EQ:   pair_kind = stc_pkg::K_EQUAL_EQUAL;
                     SCAN_BANG: pair_kind = stc_pkg::K_BANG_EQUAL;
                     SCAN_LESS: pair_kind = stc_pkg::K_LESS_EQUAL;
                     default:   pair_kind = stc_pkg::K_GREATER_EQUAL;
                  endcase
                  add_token(pair_kind, stc_pkg::ERR_NONE, tok_start, 16'd2);
                  scan_state = SCAN_IDLE;
                  taken = 1'b1;
               end
               default: ;
            endcase
            if (!taken) begin
               flush_held();
               scan_idle_byte(c, pos);
            end
            byte_pos = byte_pos + 32'd1;
         end
         for (int i = 0; i < step_tokens.size(); i++) begin
            r = step_tokens[i];
            r.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(r);
         end
      endfunction

      function void compare_field(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(stc_pkg::rec_type got);
         stc_pkg::rec_type want;
         if (expected_tokens.size() == 0) begin
            $display("%0t ns: unexpected record, expected none, actual kind %0d start %0d",
                     $time, got.token_kind, got.start_offset);
            mismatches++;
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("token_kind", want.token_kind, got.token_kind);
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("start_offset", want.start_offset, got.start_offset);
         compare_field("token_length", want.token_length, got.token_length);
         compare_field("line_number", want.line_number, got.line_number);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block under test
   // ------------------------------------------------------------------------
   localparam int LONG_RUN    = 40;      // long string, identifier and digit runs
   localparam int RANDOM_WORDS = 1850;
   localparam int HOLD_CYCLES = 300;     // long receiver stall

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = 8'd0;    // [7:0] source_byte
   logic                           req_tuser = 1'b0;    // [0] action
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [stc_pkg::RSP_DATA_W-1:0] rsp_tdata;   // [1:0] error_code, [33:2] start_offset,
                                                // [49:34] token_length, [65:50] line_number
   logic [stc_pkg::KIND_W-1:0]     rsp_tuser;   // [4:0] token_kind
   logic                           rsp_tlast;

   script_token_scanner DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   token_scoreboard sb = new();

   // driver and sink state; the first two are shared between the source driver and the record sink
   bit          steady_stretch = 1'b0;   // no idling on either side while set
   int unsigned hold_requests = 0;       // bumped by the driver, served by the sink
   int unsigned words_sent = 0;

   // character pools for the token generator
   string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string digit_chars = "0123456789";
   string blank_chars = " \t\r\n";
   string op_words [8] = '{"=", "==", "!=", "<", "<=", ">", ">=", "!"};

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------------
   // record sink: random back-pressure plus one long stall on request
   // ------------------------------------------------------------------------
   initial begin
      int unsigned      holds_done;
      int unsigned      hold_left;
      stc_pkg::rec_type got;
      holds_done = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         // values sampled here are the ones the edge saw
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.token_kind   = rsp_tuser;
            got.error_code   = rsp_tdata[1:0];
            got.start_offset = rsp_tdata[33:2];
            got.token_length = rsp_tdata[49:34];
            got.line_number  = rsp_tdata[65:50];
            got.last         = rsp_tlast;
            sb.check_result(got);
         end
         if (hold_requests != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady_stretch || ($urandom_range(99) >= 8);
         end
      end
   end

   // ------------------------------------------------------------------------
   // source driver tasks
   // ------------------------------------------------------------------------

   // offer one word and hold it until the block takes it
   task automatic send_word(input logic action, input logic [7:0] ch);
      if (!steady_stretch && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      sb.note_input(action, ch);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
   endtask

   // end of source, either as the flag or as a zero byte
   task automatic send_end();
      if ($urandom_range(1)) send_word(1'b1, 8'($urandom));
      else send_word(1'b0, stc_pkg::CH_NUL);
   endtask

   // stop offering and let every predicted record come out
   task automatic wait_for_tokens();
      req_tvalid <= 1'b0;
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one token of a plausible script, sometimes mangled, sometimes noise
   task automatic send_random_token();
      string w;
      int    pick;
      int    len;
      pick = $urandom_range(99);
      if (pick < 12) begin
         // keywords, also cut short or stretched by one letter
         w = sb.keyword_words[$urandom_range(8)];
         len = w.len();
         case ($urandom_range(3))
            0: len = len - 1;
            default: ;
         endcase
         for (int i = 0; i < len; i++) send_word(1'b0, w[i]);
         if ($urandom_range(3) == 0) send_word(1'b0, ident_chars[$urandom_range(52)]);
      end else if (pick < 30) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         send_word(1'b0, ident_chars[$urandom_range(52)]);
         for (int i = 1; i < len; i++) begin
            if ($urandom_range(3) == 0) send_word(1'b0, digit_chars[$urandom_range(9)]);
            else send_word(1'b0, ident_chars[$urandom_range(52)]);
         end
      end else if (pick < 42) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) send_word(1'b0, digit_chars[$urandom_range(9)]);
      end else if (pick < 52) begin
         // string body with newlines and the odd high byte
         send_word(1'b0, stc_pkg::CH_QUOTE);
         len = $urandom_range(0, 10);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
               0:       send_word(1'b0, stc_pkg::CH_NEWLINE);
               1:       send_word(1'b0, 8'($urandom_range(1, 255)));
               default: send_word(1'b0, 8'($urandom_range(32, 126)));
            endcase
         end
         if ($urandom_range(9) != 0) send_word(1'b0, stc_pkg::CH_QUOTE);
      end else if (pick < 70) begin
         send_text(op_words[$urandom_range(7)]);
      end else if (pick < 82) begin
         send_word(1'b0, sb.punct_chars[$urandom_range(10)]);
      end else if (pick < 92) begin
         send_word(1'b0, blank_chars[$urandom_range(3)]);
      end else if (pick < 97) begin
         send_word(1'b0, 8'($urandom_range(1, 255)));
      end else begin
         send_end();
      end
      // adjacent tokens close held ones with a byte that makes a record too
      if ($urandom_range(9) < 4) send_word(1'b0, blank_chars[$urandom_range(3)]);
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      int unsigned random_base;
      int unsigned mark;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: operator pairs, an identifier with underscore and digit,
      // all punctuation, a high byte, an unexpected printable, a lone bang
      // before a letter, then a string cut off by the end flag
      send_text("!=a_9<=>===(){}[].:,+-");
      send_word(1'b0, 8'hFF);
      send_text("@!x\"a\n");
      send_word(1'b1, 8'hA5);
      // keyword closed by a zero byte, then held operators flushed at the end
      send_text("if");
      send_word(1'b0, stc_pkg::CH_NUL);
      send_text("<");
      send_word(1'b1, 8'h00);
      send_text("\n!");
      send_word(1'b1, 8'h7E);
      wait_for_tokens();

      // long runs: a string of newlines, a long identifier and a long number
      send_word(1'b0, stc_pkg::CH_QUOTE);
      repeat (LONG_RUN) send_word(1'b0, stc_pkg::CH_NEWLINE);
      send_text("\"\nq ");
      send_end();
      send_word(1'b0, "x");
      repeat (LONG_RUN) send_word(1'b0, ident_chars[$urandom_range(52)]);
      send_text(" ");
      repeat (LONG_RUN) send_word(1'b0, digit_chars[$urandom_range(9)]);
      send_end();
      wait_for_tokens();

      // random scripts with the pressure events spread through them
      random_base = words_sent;
      mark = 0;
      while (words_sent - random_base < RANDOM_WORDS) begin
         send_random_token();
         if (mark == 0 && words_sent - random_base >= 300) begin
            // sink stalls while the driver keeps offering
            hold_requests++;
            mark = 1;
         end else if (mark == 1 && words_sent - random_base >= 800) begin
            steady_stretch = 1'b1;
            mark = 2;
         end else if (mark == 2 && words_sent - random_base >= 1200) begin
            steady_stretch = 1'b0;
            mark = 3;
         end else if (mark == 3 && words_sent - random_base >= 1500) begin
            // driver pauses until everything predicted is out
            wait_for_tokens();
            mark = 4;
         end
      end
      send_end();

      wait_for_tokens();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/stc_pkg.sv
rtl/stc_scan_core.sv
rtl/stc_out_fifo.sv
rtl/script_token_scanner.sv
tb/tb_top.sv
